// ===== design/ipv4p_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_ZERO,
    PH_DIGIT,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  typedef struct packed {
    phase_t           phase;
    logic [1:0]       parts_done;
    logic [31:0]      accum;
    logic [2:0][31:0] part;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } result_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  localparam logic [31:0] LIM_8  = 32'h0000_00ff;
  localparam logic [31:0] LIM_16 = 32'h0000_ffff;
  localparam logic [31:0] LIM_24 = 32'h00ff_ffff;

  localparam logic [1:0] PARTS_MAX = 2'd3;

endpackage

`default_nettype wire

// ===== design/ipv4p_part_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_part_acc (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step_en,
  input  wire logic [7:0]              ch,
  output ipv4p_pkg::parse_state_t      state
);

  ipv4p_pkg::phase_t  phase_r, phase_nxt;
  ipv4p_pkg::radix_t  radix_r, radix_nxt;
  logic [31:0]        accum_r, accum_nxt;
  logic [1:0]         parts_done_r, parts_done_nxt;
  logic [2:0][31:0]   part_r;
  logic               store_en;

  logic               is_dec, is_ws, is_hex_letter, is_x;
  ipv4p_pkg::radix_t  dc_radix;
  logic [31:0]        dc_accum_in, dc_scaled, dc_accum;
  ipv4p_pkg::phase_t  dc_phase;
  logic               dc_store;

  always_comb begin
    is_dec        = (ch >= ipv4p_pkg::CH_DIG0) && (ch <= ipv4p_pkg::CH_DIG9);
    is_ws         = (ch == ipv4p_pkg::CH_SPACE) ||
                    ((ch >= ipv4p_pkg::CH_TAB) && (ch <= ipv4p_pkg::CH_CR));
    is_hex_letter = ((ch >= ipv4p_pkg::CH_LO_A) && (ch <= ipv4p_pkg::CH_LO_F)) ||
                    ((ch >= ipv4p_pkg::CH_UP_A) && (ch <= ipv4p_pkg::CH_UP_F));
    is_x          = (ch == ipv4p_pkg::CH_LO_X) || (ch == ipv4p_pkg::CH_UP_X);

    dc_radix    = (phase_r == ipv4p_pkg::PH_ZERO) ? ipv4p_pkg::RX_OCT : radix_r;
    dc_accum_in = (phase_r == ipv4p_pkg::PH_ZERO) ? 32'd0 : accum_r;

    unique case (dc_radix)
      ipv4p_pkg::RX_HEX: dc_scaled = {dc_accum_in[27:0], 4'b0000};
      ipv4p_pkg::RX_OCT: dc_scaled = {dc_accum_in[28:0], 3'b000};
      default:           dc_scaled = {dc_accum_in[28:0], 3'b000} +
                                     {dc_accum_in[30:0], 1'b0};
    endcase

    dc_accum = dc_accum_in;
    dc_phase = ipv4p_pkg::PH_DIGIT;
    dc_store = 1'b0;
    priority if (is_dec) begin
      dc_accum = dc_scaled + {28'd0, ch[3:0]};
    end else if ((dc_radix == ipv4p_pkg::RX_HEX) && is_hex_letter) begin
      dc_accum = {dc_accum_in[27:0], ch[3:0] + ipv4p_pkg::HEX_LETTER_OFS};
    end else if (ch == ipv4p_pkg::CH_DOT) begin
      if (parts_done_r == ipv4p_pkg::PARTS_MAX) begin
        dc_phase = ipv4p_pkg::PH_FAIL;
      end else begin
        dc_phase = ipv4p_pkg::PH_START;
        dc_store = 1'b1;
      end
    end else if (is_ws) begin
      dc_phase = ipv4p_pkg::PH_DONE;
    end else begin
      dc_phase = ipv4p_pkg::PH_FAIL;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    radix_nxt      = radix_r;
    accum_nxt      = accum_r;
    parts_done_nxt = parts_done_r;
    store_en       = 1'b0;
    if (step_en) begin
      if (ch == ipv4p_pkg::CH_NUL) begin
        phase_nxt      = ipv4p_pkg::PH_START;
        radix_nxt      = ipv4p_pkg::RX_DEC;
        accum_nxt      = 32'd0;
        parts_done_nxt = 2'd0;
      end else begin
        unique case (phase_r)
          ipv4p_pkg::PH_START: begin
            priority if (!is_dec) begin
              phase_nxt = ipv4p_pkg::PH_FAIL;
            end else if (ch == ipv4p_pkg::CH_DIG0) begin
              accum_nxt = 32'd0;
              phase_nxt = ipv4p_pkg::PH_ZERO;
            end else begin
              radix_nxt = ipv4p_pkg::RX_DEC;
              accum_nxt = {28'd0, ch[3:0]};
              phase_nxt = ipv4p_pkg::PH_DIGIT;
            end
          end
          ipv4p_pkg::PH_ZERO: begin
            if (is_x) begin
              radix_nxt = ipv4p_pkg::RX_HEX;
              accum_nxt = 32'd0;
              phase_nxt = ipv4p_pkg::PH_DIGIT;
            end else begin
              radix_nxt = ipv4p_pkg::RX_OCT;
              accum_nxt = dc_accum;
              phase_nxt = dc_phase;
              store_en  = dc_store;
            end
          end
          ipv4p_pkg::PH_DIGIT: begin
            accum_nxt = dc_accum;
            phase_nxt = dc_phase;
            store_en  = dc_store;
          end
          ipv4p_pkg::PH_DONE: begin
            phase_nxt = ipv4p_pkg::PH_DONE;
          end
          default: begin
            phase_nxt = ipv4p_pkg::PH_FAIL;
          end
        endcase
        if (store_en) begin
          parts_done_nxt = parts_done_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ipv4p_pkg::PH_START;
      radix_r      <= ipv4p_pkg::RX_DEC;
      accum_r      <= 32'd0;
      parts_done_r <= 2'd0;
    end else begin
      phase_r      <= phase_nxt;
      radix_r      <= radix_nxt;
      accum_r      <= accum_nxt;
      parts_done_r <= parts_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (store_en && (parts_done_r == 2'(i))) begin
        part_r[i] <= dc_accum;
      end
    end
  end

  assign state.phase      = phase_r;
  assign state.parts_done = parts_done_r;
  assign state.accum      = accum_r;
  assign state.part       = part_r;

endmodule

`default_nettype wire

// ===== design/ipv4p_assemble.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_assemble (
  input  ipv4p_pkg::parse_state_t state,
  output ipv4p_pkg::result_t      result
);

  logic        phase_ok;
  logic        ok;
  logic [31:0] addr;
  logic [31:0] v;

  always_comb begin
    v        = state.accum;
    phase_ok = (state.phase == ipv4p_pkg::PH_ZERO) ||
               (state.phase == ipv4p_pkg::PH_DIGIT) ||
               (state.phase == ipv4p_pkg::PH_DONE);
    unique case (state.parts_done)
      2'd0: begin
        ok   = phase_ok;
        addr = v;
      end
      2'd1: begin
        ok   = phase_ok && (state.part[0] <= ipv4p_pkg::LIM_8) &&
               (v <= ipv4p_pkg::LIM_24);
        addr = {state.part[0][7:0], v[23:0]};
      end
      2'd2: begin
        ok   = phase_ok && (state.part[0] <= ipv4p_pkg::LIM_8) &&
               (state.part[1] <= ipv4p_pkg::LIM_8) && (v <= ipv4p_pkg::LIM_16);
        addr = {state.part[0][7:0], state.part[1][7:0], v[15:0]};
      end
      default: begin
        ok   = phase_ok && (state.part[0] <= ipv4p_pkg::LIM_8) &&
               (state.part[1] <= ipv4p_pkg::LIM_8) &&
               (state.part[2] <= ipv4p_pkg::LIM_8) && (v <= ipv4p_pkg::LIM_8);
        addr = {state.part[0][7:0], state.part[1][7:0], state.part[2][7:0], v[7:0]};
      end
    endcase
    result.ok      = ok;
    result.address = ok ? addr : 32'd0;
  end

endmodule

`default_nettype wire

// ===== design/dotted_ipv4_address_parser_unit.sv =====
// Dotted IPv4 address parser.
// Input channel: in_valid / in_stall with in_ch, one text character per
// request. A zero byte ends the string and yields exactly one result
// request on out_valid / out_stall with out_ok and out_address; every
// other character yields none. out_address is zero whenever out_ok is 0.
// Throughput: one character per cycle while in_stall is low. Each character
// waits in the input register; the per-character shift-add updates the part
// state, and the final range checks and assembly sit between that state and
// the result register, which offers a result once its zero byte is processed.
// When out_stall holds a waiting result, characters other than the zero
// byte still flow; a further zero byte waits in the input register and
// in_stall rises until the result register frees.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of the first part with no parts collected.
`timescale 1ns / 1ps
`default_nettype none

module dotted_ipv4_address_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [31:0]      out_address
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_ch_r;
  logic        s1_go;
  logic        s1_is_nul;
  logic        in_take;
  logic        out_take;
  logic        produce;

  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r;
  logic [31:0] out_address_r;

  ipv4p_pkg::parse_state_t state;
  ipv4p_pkg::result_t      result;

  assign s1_is_nul = (s1_ch_r == ipv4p_pkg::CH_NUL);
  assign out_take  = out_valid_r && !out_stall;
  assign s1_go     = s1_valid_r && (!s1_is_nul || !out_valid_r || out_take);
  assign produce   = s1_go && s1_is_nul;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r <= in_ch;
    end
    if (produce) begin
      out_ok_r      <= result.ok;
      out_address_r <= result.address;
    end
  end

  ipv4p_part_acc u_part_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_go),
    .ch      (s1_ch_r),
    .state   (state)
  );

  ipv4p_assemble u_assemble (
    .state  (state),
    .result (result)
  );

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_address = out_address_r;

  a_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_address == 32'd0)
    else $error("failed result carries a non-zero address");

  a_nul_result: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_valid)
    else $error("zero byte processed without a result");

  a_char_flows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_is_nul |-> !in_stall)
    else $error("ordinary character held in the input register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> state.phase == ipv4p_pkg::PH_START && state.parts_done == 2'd0)
    else $error("parser state not cleared after a zero byte");

endmodule

`default_nettype wire

// ===== sim/dotted_ipv4_address_parser_unit_test.sv =====
`timescale 1ns / 1ps

module dotted_ipv4_address_parser_unit_test;

  localparam int N_DIRECTED     = 34;
  localparam int RANDOM_ITEMS   = 820;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [7:0]         ch;
    logic               typed;
    ipv4p_pkg::result_t want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [31:0] out_address;

  dotted_ipv4_address_parser_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_ch       (in_ch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_ok      (out_ok),
    .out_address (out_address)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  ipv4p_pkg::phase_t  cur_phase;
  ipv4p_pkg::radix_t  cur_radix;
  logic [31:0]        part_val;
  logic [1:0]         parts_seen;
  logic [31:0]        done_parts [3];

  ipv4p_pkg::result_t addr_expected [$];
  ipv4p_pkg::result_t oldest;
  logic [7:0]         text_q [$];
  step_row_t          directed_rows [N_DIRECTED];
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  bit                 hold_ask = 1'b0;
  int                 fail_count = 0;
  int                 quiet_cycles = 0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= ipv4p_pkg::CH_DIG0 && c <= ipv4p_pkg::CH_DIG9;
  endfunction

  task automatic clear_parser();
    cur_phase  = ipv4p_pkg::PH_START;
    cur_radix  = ipv4p_pkg::RX_DEC;
    part_val   = '0;
    parts_seen = '0;
    done_parts = '{default: '0};
  endtask

  task automatic take_digit(input logic [7:0] c);
    logic [31:0] weight;
    case (cur_radix)
      ipv4p_pkg::RX_HEX: weight = 32'd16;
      ipv4p_pkg::RX_OCT: weight = 32'd8;
      default:           weight = 32'd10;
    endcase
    if (is_digit(c)) begin
      part_val = part_val * weight + {24'd0, c - ipv4p_pkg::CH_DIG0};
    end else if (cur_radix == ipv4p_pkg::RX_HEX &&
                 c >= ipv4p_pkg::CH_LO_A && c <= ipv4p_pkg::CH_LO_F) begin
      part_val = (part_val << 4) + {24'd0, c - ipv4p_pkg::CH_LO_A} + 32'd10;
    end else if (cur_radix == ipv4p_pkg::RX_HEX &&
                 c >= ipv4p_pkg::CH_UP_A && c <= ipv4p_pkg::CH_UP_F) begin
      part_val = (part_val << 4) + {24'd0, c - ipv4p_pkg::CH_UP_A} + 32'd10;
    end else if (c == ipv4p_pkg::CH_DOT) begin
      if (parts_seen == ipv4p_pkg::PARTS_MAX) begin
        cur_phase = ipv4p_pkg::PH_FAIL;
      end else begin
        done_parts[parts_seen] = part_val;
        parts_seen = parts_seen + 2'd1;
        cur_phase = ipv4p_pkg::PH_START;
      end
    end else if (c == ipv4p_pkg::CH_SPACE ||
                 (c >= ipv4p_pkg::CH_TAB && c <= ipv4p_pkg::CH_CR)) begin
      cur_phase = ipv4p_pkg::PH_DONE;
    end else begin
      cur_phase = ipv4p_pkg::PH_FAIL;
    end
  endtask

  function automatic ipv4p_pkg::result_t assemble_address();
    ipv4p_pkg::result_t r;
    bit                 fit;
    r = '0;
    if (cur_phase == ipv4p_pkg::PH_START || cur_phase == ipv4p_pkg::PH_FAIL) return r;
    case (parts_seen)
      2'd0: begin
        fit = 1'b1;
        r.address = part_val;
      end
      2'd1: begin
        fit = done_parts[0] <= ipv4p_pkg::LIM_8 && part_val <= ipv4p_pkg::LIM_24;
        r.address = {done_parts[0][7:0], part_val[23:0]};
      end
      2'd2: begin
        fit = done_parts[0] <= ipv4p_pkg::LIM_8 && done_parts[1] <= ipv4p_pkg::LIM_8 &&
              part_val <= ipv4p_pkg::LIM_16;
        r.address = {done_parts[0][7:0], done_parts[1][7:0], part_val[15:0]};
      end
      default: begin
        fit = done_parts[0] <= ipv4p_pkg::LIM_8 && done_parts[1] <= ipv4p_pkg::LIM_8 &&
              done_parts[2] <= ipv4p_pkg::LIM_8 && part_val <= ipv4p_pkg::LIM_8;
        r.address = {done_parts[0][7:0], done_parts[1][7:0], done_parts[2][7:0],
                     part_val[7:0]};
      end
    endcase
    if (!fit) r = '0;
    else r.ok = 1'b1;
    return r;
  endfunction

  task automatic advance_parser(input logic [7:0] c, output bit has_res,
                                output ipv4p_pkg::result_t res);
    has_res = 1'b0;
    res = '0;
    if (c == ipv4p_pkg::CH_NUL) begin
      has_res = 1'b1;
      res = assemble_address();
      clear_parser();
    end else begin
      case (cur_phase)
        ipv4p_pkg::PH_START: begin
          if (!is_digit(c)) begin
            cur_phase = ipv4p_pkg::PH_FAIL;
          end else if (c == ipv4p_pkg::CH_DIG0) begin
            part_val = '0;
            cur_phase = ipv4p_pkg::PH_ZERO;
          end else begin
            cur_radix = ipv4p_pkg::RX_DEC;
            part_val = {24'd0, c - ipv4p_pkg::CH_DIG0};
            cur_phase = ipv4p_pkg::PH_DIGIT;
          end
        end
        ipv4p_pkg::PH_ZERO: begin
          part_val = '0;
          cur_phase = ipv4p_pkg::PH_DIGIT;
          if (c == ipv4p_pkg::CH_LO_X || c == ipv4p_pkg::CH_UP_X) begin
            cur_radix = ipv4p_pkg::RX_HEX;
          end else begin
            cur_radix = ipv4p_pkg::RX_OCT;
            take_digit(c);
          end
        end
        ipv4p_pkg::PH_DIGIT: take_digit(c);
        ipv4p_pkg::PH_DONE: ;
        default: cur_phase = ipv4p_pkg::PH_FAIL;
      endcase
    end
  endtask

  task automatic send_char(input logic [7:0] c, input bit typed,
                           input ipv4p_pkg::result_t typed_res);
    bit                 has_res;
    ipv4p_pkg::result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_parser(c, has_res, got);
    if (has_res) addr_expected.push_back(typed ? typed_res : got);
  endtask

  function automatic step_row_t ch_row(input logic [7:0] c);
    step_row_t r;
    r = '0;
    r.ch = c;
    return r;
  endfunction

  // string end; typed rows expect a rejected address
  function automatic step_row_t end_row(input bit typed);
    step_row_t r;
    r = '0;
    r.ch = ipv4p_pkg::CH_NUL;
    r.typed = typed;
    return r;
  endfunction

  task automatic add_decimal(input logic [31:0] v);
    logic [7:0] digs [$];
    do begin
      digs.push_front(ipv4p_pkg::CH_DIG0 + 8'(v % 32'd10));
      v = v / 32'd10;
    end while (v != 0);
    foreach (digs[k]) text_q.push_back(digs[k]);
  endtask

  task automatic add_part(input bit last);
    int         fmt, n, k;
    bit         wide, loose;
    logic [3:0] nib;
    fmt = $urandom_range(0, 9);
    wide = last && ($urandom_range(0, 3) == 0);
    if (fmt < 6) begin
      if (wide) begin
        add_decimal($urandom);
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++)
          text_q.push_back(ipv4p_pkg::CH_DIG0 + 8'($urandom_range(0, 9)));
      end else if ($urandom_range(0, 6) == 0) begin
        add_decimal($urandom_range(256, 999));
      end else begin
        add_decimal($urandom_range(0, 255));
      end
    end else if (fmt < 8) begin
      loose = ($urandom_range(0, 3) == 0);
      text_q.push_back(ipv4p_pkg::CH_DIG0);
      n = wide ? $urandom_range(0, 11) : $urandom_range(0, 3);
      for (k = 0; k < n; k++)
        text_q.push_back(ipv4p_pkg::CH_DIG0 + 8'($urandom_range(0, loose ? 9 : 7)));
    end else begin
      text_q.push_back(ipv4p_pkg::CH_DIG0);
      text_q.push_back($urandom_range(0, 1) ? ipv4p_pkg::CH_UP_X : ipv4p_pkg::CH_LO_X);
      n = wide ? $urandom_range(0, 8) : $urandom_range(0, 2);
      for (k = 0; k < n; k++) begin
        nib = 4'($urandom_range(0, 15));
        if (nib < 4'd10) text_q.push_back(ipv4p_pkg::CH_DIG0 + 8'(nib));
        else text_q.push_back(($urandom_range(0, 1) ? ipv4p_pkg::CH_UP_A : ipv4p_pkg::CH_LO_A)
                              + 8'(nib) - 8'd10);
      end
    end
  endtask

  task automatic compose_text();
    int         nparts, p, tail, n, k;
    logic [7:0] junk;
    text_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      nparts = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
      for (p = 0; p < nparts; p++) begin
        if (p > 0) text_q.push_back(ipv4p_pkg::CH_DOT);
        add_part(p == nparts - 1);
      end
      tail = $urandom_range(0, 99);
      junk = 8'($urandom_range(1, 255));
      if (tail < 10) begin
        n = $urandom_range(0, 6);
        text_q.push_back(n == 6 ? ipv4p_pkg::CH_SPACE : ipv4p_pkg::CH_TAB + 8'(n));
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) text_q.push_back(8'($urandom_range(1, 255)));
      end else if (tail < 16) begin
        text_q.push_back(junk);
        text_q.push_back(8'($urandom_range(1, 255)));
      end else if (tail < 20) begin
        text_q.insert($urandom_range(0, text_q.size() - 1), junk);
      end else if (tail < 23) begin
        text_q.push_back(ipv4p_pkg::CH_DOT);
      end
    end
    text_q.push_back(ipv4p_pkg::CH_NUL);
  endtask

  initial begin
    bit hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (addr_expected.size() == 0) begin
        $error("out_ok/out_address: expected no request, got ok=%0b address=%h",
               out_ok, out_address);
        fail_count++;
      end else begin
        oldest = addr_expected.pop_front();
        if (out_ok !== oldest.ok) begin
          $error("out_ok: expected %0b, got %0b", oldest.ok, out_ok);
          fail_count++;
        end
        if (out_address !== oldest.address) begin
          $error("out_address: expected %h, got %h", oldest.address, out_address);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL dotted_ipv4_address_parser_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int    r, k, sent;
    string probe;
    clear_parser();
    directed_rows = '{
      end_row(1'b1),
      ch_row(ipv4p_pkg::CH_DIG0), ch_row(ipv4p_pkg::CH_LO_X), ch_row(ipv4p_pkg::CH_DOT),
      ch_row(ipv4p_pkg::CH_DIG0), ch_row(ipv4p_pkg::CH_DIG0 + 8'd8), end_row(1'b0),
      ch_row(ipv4p_pkg::CH_DIG0), ch_row(ipv4p_pkg::CH_DOT), ch_row(ipv4p_pkg::CH_DIG0),
      ch_row(ipv4p_pkg::CH_DOT), ch_row(ipv4p_pkg::CH_DIG0), ch_row(ipv4p_pkg::CH_DOT),
      ch_row(ipv4p_pkg::CH_DIG0), ch_row(ipv4p_pkg::CH_DOT), end_row(1'b1),
      ch_row(ipv4p_pkg::CH_DIG0 + 8'd3), ch_row(ipv4p_pkg::CH_DOT), end_row(1'b1),
      ch_row(ipv4p_pkg::CH_DIG0 + 8'd7), ch_row(ipv4p_pkg::CH_SPACE), ch_row(8'hFF),
      end_row(1'b0),
      ch_row(ipv4p_pkg::CH_DIG0), ch_row(ipv4p_pkg::CH_UP_X), ch_row(ipv4p_pkg::CH_LO_F),
      ch_row(8'h80), end_row(1'b1),
      ch_row(ipv4p_pkg::CH_DIG9), ch_row(ipv4p_pkg::CH_DIG9), ch_row(ipv4p_pkg::CH_DIG9),
      ch_row(ipv4p_pkg::CH_DOT), ch_row(ipv4p_pkg::CH_DIG0), end_row(1'b1)
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct <= 59;
    for (r = 0; r < N_DIRECTED; r++)
      send_char(directed_rows[r].ch, directed_rows[r].typed, directed_rows[r].want);

    // hold the result side while requests keep coming
    send_idle_pct = 0;
    hold_ask <= ~hold_ask;
    probe = "192.168.10.255";
    repeat (3) begin
      for (k = 0; k < probe.len(); k++) send_char(probe[k], 1'b0, '0);
      send_char(ipv4p_pkg::CH_NUL, 1'b0, '0);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct <= 59;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct <= 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      compose_text();
      foreach (text_q[k]) send_char(text_q[k], 1'b0, '0);
      sent += text_q.size();
    end
    in_valid <= 1'b0;

    while (addr_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS dotted_ipv4_address_parser_unit");
    end else begin
      $display("FAIL dotted_ipv4_address_parser_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ipv4p_pkg.sv
design/ipv4p_part_acc.sv
design/ipv4p_assemble.sv
design/dotted_ipv4_address_parser_unit.sv
sim/dotted_ipv4_address_parser_unit_test.sv
